[rtl/core/mce_pkg.sv]
package mce_pkg;

  localparam int RF_DEPTH = 512;
  localparam int RF_AW = 9;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int EEPROM_DEPTH_DEF = 256;

  localparam logic [8:0] A_PCL    = 9'h002;
  localparam logic [8:0] A_STATUS = 9'h003;
  localparam logic [8:0] A_FSR    = 9'h004;
  localparam logic [8:0] A_PORTA  = 9'h005;
  localparam logic [8:0] A_PORTB  = 9'h006;
  localparam logic [8:0] A_PORTC  = 9'h007;
  localparam logic [8:0] A_PORTD  = 9'h008;
  localparam logic [8:0] A_PORTE  = 9'h009;
  localparam logic [8:0] A_PCLATH = 9'h00A;
  localparam logic [8:0] A_PIR1   = 9'h00C;
  localparam logic [8:0] A_RCSTA  = 9'h018;
  localparam logic [8:0] A_RCREG  = 9'h01A;
  localparam logic [8:0] A_TRISA  = 9'h085;
  localparam logic [8:0] A_TRISB  = 9'h086;
  localparam logic [8:0] A_TRISC  = 9'h087;
  localparam logic [8:0] A_TRISD  = 9'h088;
  localparam logic [8:0] A_TRISE  = 9'h089;
  localparam logic [8:0] A_TXSTA  = 9'h098;
  localparam logic [8:0] A_EEDATA = 9'h10C;
  localparam logic [8:0] A_EEADR  = 9'h10D;
  localparam logic [8:0] A_EECON1 = 9'h18C;
  localparam logic [8:0] A_TRIS_BASE = 9'h084;

  localparam logic [2:0] FLT_OK    = 3'd0;
  localparam logic [2:0] FLT_BADOP = 3'd1;
  localparam logic [2:0] FLT_OVF   = 3'd2;
  localparam logic [2:0] FLT_UNF   = 3'd3;
  localparam logic [2:0] FLT_PMEM  = 3'd4;

  typedef enum logic [5:0] {
    K_BAD, K_NOP, K_RET, K_MOVWF, K_TRIS, K_CLRF, K_CLRW,
    K_SUBWF, K_DECF, K_IORWF, K_ANDWF, K_XORWF, K_ADDWF, K_MOVF, K_COMF,
    K_INCF, K_DECFSZ, K_RRF, K_RLF, K_SWAPF, K_INCFSZ,
    K_BCF, K_BSF, K_BTFSC, K_BTFSS,
    K_CALL, K_GOTO, K_MOVLW, K_RETLW, K_IORLW, K_ANDLW, K_XORLW, K_SUBLW, K_ADDLW
  } kind_t;

  typedef enum logic {PH_ISSUE, PH_EXEC} phase_t;

  typedef struct packed {
    logic [13:0]     op;
    logic [4:0][7:0] pins;
    kind_t           kind;
  } item_t;

  typedef struct packed {
    logic [12:0] next_pc;
    logic [7:0]  w_value;
    logic [7:0]  status_value;
    logic [1:0]  cycles_used;
    logic [2:0]  fault;
    logic        reg_written;
    logic [8:0]  written_address;
    logic [7:0]  written_value;
  } result_t;

endpackage

[rtl/core/mce_fifo.sv]
module mce_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] slot [2];
  logic             wp;
  logic             rp;
  logic [1:0]       cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= !wp;
      if (do_pop) rp <= !rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= din;
  end

endmodule

[rtl/core/mce_front.sv]
module mce_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic [13:0]       instruction_word,
  input  logic [4:0][7:0]   pins,
  output logic              out_valid,
  output mce_pkg::item_t    out_item,
  input  logic              take
);

  mce_pkg::kind_t kind;
  mce_pkg::item_t item;
  logic           q_empty;
  logic [13:0]    op;

  assign op = instruction_word;

  // classify the opcode before it is queued
  always_comb begin
    kind = mce_pkg::K_BAD;
    unique case (op[13:12])
      2'd0: begin
        if (op[11:8] == 4'd0) begin
          if ((op & 14'h3F9F) == 14'd0) kind = mce_pkg::K_NOP;
          else if (op == 14'h0008) kind = mce_pkg::K_RET;
          else if (op[7]) kind = mce_pkg::K_MOVWF;
          else if ((op & 14'h3FFC) == 14'h0064) kind = mce_pkg::K_TRIS;
          else kind = mce_pkg::K_BAD;
        end else if (op[11:8] == 4'd1) begin
          kind = op[7] ? mce_pkg::K_CLRF : mce_pkg::K_CLRW;
        end else begin
          kind = mce_pkg::kind_t'(6'(int'(mce_pkg::K_SUBWF) + int'(op[11:8]) - 2));
        end
      end
      2'd1: kind = mce_pkg::kind_t'(6'(int'(mce_pkg::K_BCF) + int'(op[11:10])));
      2'd2: kind = op[11] ? mce_pkg::K_GOTO : mce_pkg::K_CALL;
      2'd3: begin
        unique case (op[11:10])
          2'd0: kind = mce_pkg::K_MOVLW;
          2'd1: kind = mce_pkg::K_RETLW;
          2'd2: begin
            unique case (op[9:8])
              2'd0: kind = mce_pkg::K_IORLW;
              2'd1: kind = mce_pkg::K_ANDLW;
              2'd2: kind = mce_pkg::K_XORLW;
              default: kind = mce_pkg::K_BAD;
            endcase
          end
          default: kind = op[9] ? mce_pkg::K_ADDLW : mce_pkg::K_SUBLW;
        endcase
      end
      default: kind = mce_pkg::K_BAD;
    endcase
  end

  always_comb begin
    item.op   = op;
    item.pins = pins;
    item.kind = kind;
  end

  mce_fifo #(
    .WIDTH($bits(mce_pkg::item_t))
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .din  (item),
    .pop  (take),
    .empty(q_empty),
    .dout (out_item)
  );

  assign out_valid = !q_empty;

endmodule

[rtl/core/mce_back.sv]
module mce_back #(
  parameter int STACK_DEPTH  = mce_pkg::STACK_DEPTH_DEF,
  parameter int EEPROM_DEPTH = mce_pkg::EEPROM_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  mce_pkg::item_t   in_item,
  output logic             take,
  output logic             res_push,
  output mce_pkg::result_t res_item,
  input  logic             res_full,
  output logic             clearing
);

  localparam int SLW = $clog2(STACK_DEPTH + 1);
  localparam int SIW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int EIW = $clog2(EEPROM_DEPTH);
  localparam int CW  = mce_pkg::RF_AW + 1;

  mce_pkg::phase_t ph;
  mce_pkg::phase_t ph_next;

  mce_pkg::item_t cur;
  logic [8:0]     a_q;
  logic           ind_q;
  logic [7:0]     rdata;
  logic [7:0]     ee_rdata;

  logic [12:0]     pc;
  logic [7:0]      w;
  logic [7:0]      status;
  logic [7:0]      fsr;
  logic [7:0]      pclath;
  logic [7:0]      pir1;
  logic [7:0]      rcsta;
  logic [7:0]      txsta;
  logic [7:0]      eedata;
  logic [7:0]      eeadr;
  logic [4:0][7:0] tris;
  logic [12:0]     stack [STACK_DEPTH];
  logic [SLW-1:0]  level;
  logic [CW-1:0]   clr_cnt;

  logic [7:0] mem [mce_pkg::RF_DEPTH];
  logic [7:0] eeprom [EEPROM_DEPTH];

  // issue side
  logic [8:0]     rd_addr;
  logic           rd_ind;
  logic [8:0]     ea_rem;
  logic [EIW-1:0] ea;

  // execute side
  logic [13:0]     op;
  logic [7:0]      k;
  logic [2:0]      bitn;
  logic [7:0]      raw;
  logic [7:0]      v;
  logic [7:0]      res;
  logic [8:0]      wide;
  logic            to_f;
  logic            to_w;
  logic            zf;
  logic            cf;
  logic            cval;
  logic            skip;
  logic            jump;
  logic            push_stk;
  logic            pop_stk;
  logic            rd;
  logic [2:0]      fault;
  logic [7:0]      stored;
  logic            pcl_wr;
  logic            ee_rd;
  logic            ee_wr;
  logic [12:0]     pc_inc;
  logic [12:0]     npc;
  logic [1:0]      cycles;
  logic [7:0]      w_n;
  logic [7:0]      status_n;
  logic [7:0]      fsr_n;
  logic [7:0]      pclath_n;
  logic [7:0]      pir1_n;
  logic [7:0]      rcsta_n;
  logic [7:0]      txsta_n;
  logic [7:0]      eedata_n;
  logic [7:0]      eeadr_n;
  logic [4:0][7:0] tris_n;
  logic [SIW-1:0]  pop_idx;
  logic            commit;

  assign clearing = !clr_cnt[CW-1];

  always_comb begin
    ph_next = ph;
    unique case (ph)
      mce_pkg::PH_ISSUE: if (take) ph_next = mce_pkg::PH_EXEC;
      mce_pkg::PH_EXEC:  ph_next = mce_pkg::PH_ISSUE;
      default:           ph_next = mce_pkg::PH_ISSUE;
    endcase
  end

  always_comb begin
    take     = 1'b0;
    res_push = 1'b0;
    unique case (ph)
      mce_pkg::PH_ISSUE: take = !clearing && in_valid && !res_full;
      mce_pkg::PH_EXEC:  res_push = 1'b1;
      default: ;
    endcase
  end

  // resolve the operand address from the banking and FSR state
  always_comb begin
    rd_ind  = 1'b0;
    rd_addr = {status[6:5], in_item.op[6:0]};
    if (in_item.kind == mce_pkg::K_TRIS) begin
      rd_ind  = 1'b1;
      rd_addr = mce_pkg::A_TRIS_BASE + {7'd0, in_item.op[1:0]};
    end else if (in_item.op[6:0] == 7'd0) begin
      rd_ind  = 1'b1;
      rd_addr = {status[7], fsr};
    end else if (in_item.op[6:0] == mce_pkg::A_PCL[6:0] ||
                 in_item.op[6:0] == mce_pkg::A_STATUS[6:0] ||
                 in_item.op[6:0] == mce_pkg::A_FSR[6:0] ||
                 in_item.op[6:0] == mce_pkg::A_PCLATH[6:0]) begin
      rd_addr = {2'd0, in_item.op[6:0]};
    end
  end

  // EEADR modulo the EEPROM depth by restoring subtraction
  always_comb begin
    ea_rem = {1'b0, eeadr};
    for (int i = 7; i >= 0; i--) begin
      if (17'(ea_rem) >= (17'(EEPROM_DEPTH) << i)) ea_rem = 9'(17'(ea_rem) - (17'(EEPROM_DEPTH) << i));
    end
    ea = ea_rem[EIW-1:0];
  end

  always_comb begin
    op      = cur.op;
    k       = op[7:0];
    bitn    = op[9:7];
    pc_inc  = pc + 13'd1;
    pop_idx = SIW'(level - SLW'(1));

    unique case (a_q)
      mce_pkg::A_STATUS: raw = status;
      mce_pkg::A_FSR:    raw = fsr;
      mce_pkg::A_PCLATH: raw = pclath;
      mce_pkg::A_PIR1:   raw = pir1;
      mce_pkg::A_RCSTA:  raw = rcsta;
      mce_pkg::A_TXSTA:  raw = txsta;
      mce_pkg::A_EEDATA: raw = eedata;
      mce_pkg::A_EEADR:  raw = eeadr;
      mce_pkg::A_TRISA:  raw = tris[0];
      mce_pkg::A_TRISB:  raw = tris[1];
      mce_pkg::A_TRISC:  raw = tris[2];
      mce_pkg::A_TRISD:  raw = tris[3];
      mce_pkg::A_TRISE:  raw = tris[4];
      default:           raw = rdata;
    endcase

    v = raw;
    if (!ind_q) begin
      case (a_q)
        mce_pkg::A_PCL:   v = pc_inc[7:0];
        mce_pkg::A_PORTA: v = (raw & ~tris[0]) | (cur.pins[0] & tris[0]);
        mce_pkg::A_PORTB: v = (raw & ~tris[1]) | (cur.pins[1] & tris[1]);
        mce_pkg::A_PORTC: v = (raw & ~tris[2]) | (cur.pins[2] & tris[2]);
        mce_pkg::A_PORTD: v = (raw & ~tris[3]) | (cur.pins[3] & tris[3]);
        mce_pkg::A_PORTE: v = (raw & ~tris[4]) | (cur.pins[4] & tris[4]);
        mce_pkg::A_PIR1:  v = raw | 8'h10;
        mce_pkg::A_TXSTA: v = raw | 8'h02;
        default: ;
      endcase
    end

    rd   = cur.kind inside {[mce_pkg::K_SUBWF:mce_pkg::K_BTFSS]};
    res  = 8'd0;
    wide = 9'd0;
    to_f = 1'b0;
    to_w = 1'b0;
    zf   = 1'b0;
    cf   = 1'b0;
    cval = 1'b0;
    skip = 1'b0;
    jump = 1'b0;
    push_stk = 1'b0;
    pop_stk  = 1'b0;
    if (cur.kind inside {[mce_pkg::K_SUBWF:mce_pkg::K_INCFSZ]}) begin
      to_f = op[7];
      to_w = !op[7];
    end

    unique case (cur.kind)
      mce_pkg::K_RETLW: begin
        res = k;
        to_w = 1'b1;
        pop_stk = 1'b1;
      end
      mce_pkg::K_RET:   pop_stk = 1'b1;
      mce_pkg::K_MOVWF: begin
        res = w;
        to_f = 1'b1;
      end
      mce_pkg::K_TRIS: begin
        if (op[1:0] != 2'd0) begin
          res = w;
          to_f = 1'b1;
        end
      end
      mce_pkg::K_CLRF: begin
        to_f = 1'b1;
        zf = 1'b1;
      end
      mce_pkg::K_CLRW: begin
        to_w = 1'b1;
        zf = 1'b1;
      end
      mce_pkg::K_SUBWF: begin
        wide = {1'b0, v} - {1'b0, w};
        res = wide[7:0];
        cf = 1'b1;
        cval = !wide[8];
        zf = 1'b1;
      end
      mce_pkg::K_DECF: begin
        res = v - 8'd1;
        zf = 1'b1;
      end
      mce_pkg::K_IORWF: begin
        res = v | w;
        zf = 1'b1;
      end
      mce_pkg::K_ANDWF: begin
        res = v & w;
        zf = 1'b1;
      end
      mce_pkg::K_XORWF: begin
        res = v ^ w;
        zf = 1'b1;
      end
      mce_pkg::K_ADDWF: begin
        wide = {1'b0, v} + {1'b0, w};
        res = wide[7:0];
        cf = 1'b1;
        cval = wide[8];
        zf = 1'b1;
      end
      mce_pkg::K_MOVF: begin
        res = v;
        zf = 1'b1;
      end
      mce_pkg::K_COMF: begin
        res = ~v;
        zf = 1'b1;
      end
      mce_pkg::K_INCF: begin
        res = v + 8'd1;
        zf = 1'b1;
      end
      mce_pkg::K_DECFSZ: begin
        res = v - 8'd1;
        skip = (res == 8'd0);
      end
      mce_pkg::K_INCFSZ: begin
        res = v + 8'd1;
        skip = (res == 8'd0);
      end
      mce_pkg::K_RRF: begin
        res = {status[0], v[7:1]};
        cf = 1'b1;
        cval = v[0];
      end
      mce_pkg::K_RLF: begin
        res = {v[6:0], status[0]};
        cf = 1'b1;
        cval = v[7];
      end
      mce_pkg::K_SWAPF: res = {v[3:0], v[7:4]};
      mce_pkg::K_BCF: begin
        res = v & ~(8'd1 << bitn);
        to_f = 1'b1;
      end
      mce_pkg::K_BSF: begin
        res = v | (8'd1 << bitn);
        to_f = 1'b1;
      end
      mce_pkg::K_BTFSC: skip = !v[bitn];
      mce_pkg::K_BTFSS: skip = v[bitn];
      mce_pkg::K_CALL: begin
        jump = 1'b1;
        push_stk = 1'b1;
      end
      mce_pkg::K_GOTO:  jump = 1'b1;
      mce_pkg::K_MOVLW: begin
        res = k;
        to_w = 1'b1;
      end
      mce_pkg::K_IORLW: begin
        res = w | k;
        to_w = 1'b1;
        zf = 1'b1;
      end
      mce_pkg::K_ANDLW: begin
        res = w & k;
        to_w = 1'b1;
        zf = 1'b1;
      end
      mce_pkg::K_XORLW: begin
        res = w ^ k;
        to_w = 1'b1;
        zf = 1'b1;
      end
      mce_pkg::K_SUBLW: begin
        wide = {1'b0, k} - {1'b0, w};
        res = wide[7:0];
        to_w = 1'b1;
        cf = 1'b1;
        cval = !wide[8];
        zf = 1'b1;
      end
      mce_pkg::K_ADDLW: begin
        wide = {1'b0, k} + {1'b0, w};
        res = wide[7:0];
        to_w = 1'b1;
        cf = 1'b1;
        cval = wide[8];
        zf = 1'b1;
      end
      default: ;
    endcase

    if (cur.kind == mce_pkg::K_BAD) fault = mce_pkg::FLT_BADOP;
    else if (push_stk && level == SLW'(STACK_DEPTH)) fault = mce_pkg::FLT_OVF;
    else if (pop_stk && level == SLW'(0)) fault = mce_pkg::FLT_UNF;
    else if (to_f && !ind_q && a_q == mce_pkg::A_EECON1 && res[7] && res[1:0] != 2'd0)
      fault = mce_pkg::FLT_PMEM;
    else fault = mce_pkg::FLT_OK;

    // special writes: PCL redirects the PC, RCSTA keeps OERR while CREN is set, EECON1 self-clears RD/WR
    stored = res;
    pcl_wr = 1'b0;
    ee_rd  = 1'b0;
    ee_wr  = 1'b0;
    if (to_f && !ind_q) begin
      if (a_q == mce_pkg::A_PCL) begin
        pcl_wr = 1'b1;
      end else if (a_q == mce_pkg::A_RCSTA) begin
        stored[1] = res[4] & rcsta[1];
      end else if (a_q == mce_pkg::A_EECON1) begin
        if (res[0]) begin
          ee_rd = 1'b1;
          stored[0] = 1'b0;
        end else if (res[1]) begin
          ee_wr = 1'b1;
          stored[1] = 1'b0;
        end
      end
    end

    npc    = pc_inc;
    cycles = 2'd1;
    if (jump) begin
      npc = {pclath[4:3], op[10:0]};
      cycles = 2'd2;
    end
    if (skip) begin
      npc = pc + 13'd2;
      cycles = 2'd2;
    end
    if (pcl_wr) begin
      npc = {pclath[4:0], stored};
      cycles = 2'd2;
    end
    if (pop_stk) begin
      npc = stack[pop_idx];
      cycles = 2'd2;
    end

    // read side effects, then the write, then the flags
    pir1_n   = pir1;
    txsta_n  = txsta;
    if (rd && !ind_q) begin
      if (a_q == mce_pkg::A_RCREG) pir1_n[5] = 1'b0;
      else if (a_q == mce_pkg::A_PIR1) pir1_n[4] = 1'b1;
      else if (a_q == mce_pkg::A_TXSTA) txsta_n[1] = 1'b1;
    end
    status_n = status;
    fsr_n    = fsr;
    pclath_n = pclath;
    rcsta_n  = rcsta;
    eedata_n = ee_rd ? ee_rdata : eedata;
    eeadr_n  = eeadr;
    tris_n   = tris;
    if (to_f) begin
      case (a_q)
        mce_pkg::A_STATUS: status_n = stored;
        mce_pkg::A_FSR:    fsr_n = stored;
        mce_pkg::A_PCLATH: pclath_n = stored;
        mce_pkg::A_PIR1:   pir1_n = stored;
        mce_pkg::A_RCSTA:  rcsta_n = stored;
        mce_pkg::A_TXSTA:  txsta_n = stored;
        mce_pkg::A_EEDATA: eedata_n = stored;
        mce_pkg::A_EEADR:  eeadr_n = stored;
        mce_pkg::A_TRISA:  tris_n[0] = stored;
        mce_pkg::A_TRISB:  tris_n[1] = stored;
        mce_pkg::A_TRISC:  tris_n[2] = stored;
        mce_pkg::A_TRISD:  tris_n[3] = stored;
        mce_pkg::A_TRISE:  tris_n[4] = stored;
        default: ;
      endcase
    end
    if (zf) status_n[2] = (res == 8'd0);
    if (cf) status_n[0] = cval;
    w_n = to_w ? res : w;

    commit = (ph == mce_pkg::PH_EXEC) && (fault == mce_pkg::FLT_OK);

    if (fault != mce_pkg::FLT_OK) begin
      res_item.next_pc         = pc;
      res_item.w_value         = w;
      res_item.status_value    = status;
      res_item.cycles_used     = 2'd1;
      res_item.fault           = fault;
      res_item.reg_written     = 1'b0;
      res_item.written_address = 9'd0;
      res_item.written_value   = 8'd0;
    end else begin
      res_item.next_pc         = npc;
      res_item.w_value         = w_n;
      res_item.status_value    = status_n;
      res_item.cycles_used     = cycles;
      res_item.fault           = mce_pkg::FLT_OK;
      res_item.reg_written     = to_f;
      res_item.written_address = to_f ? a_q : 9'd0;
      res_item.written_value   = to_f ? stored : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph      <= mce_pkg::PH_ISSUE;
      pc      <= 13'd0;
      w       <= 8'd0;
      status  <= 8'd0;
      fsr     <= 8'd0;
      pclath  <= 8'd0;
      pir1    <= 8'd0;
      rcsta   <= 8'd0;
      txsta   <= 8'd0;
      eedata  <= 8'd0;
      eeadr   <= 8'd0;
      tris    <= '0;
      level   <= '0;
      clr_cnt <= '0;
    end else begin
      ph <= ph_next;
      if (clearing) clr_cnt <= clr_cnt + CW'(1);
      if (commit) begin
        pc     <= npc;
        w      <= w_n;
        status <= status_n;
        fsr    <= fsr_n;
        pclath <= pclath_n;
        pir1   <= pir1_n;
        rcsta  <= rcsta_n;
        txsta  <= txsta_n;
        eedata <= eedata_n;
        eeadr  <= eeadr_n;
        tris   <= tris_n;
        if (push_stk) level <= level + SLW'(1);
        else if (pop_stk) level <= level - SLW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur   <= in_item;
      a_q   <= rd_addr;
      ind_q <= rd_ind;
    end
    if (commit && push_stk) stack[level[SIW-1:0]] <= pc_inc;
  end

  always_ff @(posedge clk) begin
    if (clearing) mem[clr_cnt[mce_pkg::RF_AW-1:0]] <= 8'd0;
    else if (commit && to_f) mem[a_q] <= stored;
    if (take) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (clearing && clr_cnt < CW'(EEPROM_DEPTH)) eeprom[clr_cnt[EIW-1:0]] <= 8'd0;
    else if (commit && ee_wr) eeprom[ea] <= eedata;
    if (take) ee_rdata <= eeprom[ea];
  end

endmodule

[rtl/core/midrange_8bit_core_execute.sv]
// Channel  | Handshake              | Words
// ---------+------------------------+-----------------------------------------------
// input    | push / full            | instruction_word, port_a_in .. port_e_in
// result   | pop / empty            | next_pc, w_value, status_value, cycles_used,
//          |                        | fault, reg_written, written_address, written_value
//
// Each instruction passes through an issue phase in the execute unit that reads the register
// file and EEPROM memories, then an execute phase that computes and writes back.
// After reset, full stays high while the register file and EEPROM
// are swept to zero.
// A two-word queue on each side lets input and result stall independently.
module midrange_8bit_core_execute #(
  parameter int STACK_DEPTH  = mce_pkg::STACK_DEPTH_DEF,
  parameter int EEPROM_DEPTH = mce_pkg::EEPROM_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [13:0] instruction_word,
  input  logic [7:0]  port_a_in,
  input  logic [7:0]  port_b_in,
  input  logic [7:0]  port_c_in,
  input  logic [7:0]  port_d_in,
  input  logic [7:0]  port_e_in,
  input  logic        pop,
  output logic        empty,
  output logic [12:0] next_pc,
  output logic [7:0]  w_value,
  output logic [7:0]  status_value,
  output logic [1:0]  cycles_used,
  output logic [2:0]  fault,
  output logic        reg_written,
  output logic [8:0]  written_address,
  output logic [7:0]  written_value
);

  logic             q_full;
  logic             clearing;
  logic             f_valid;
  mce_pkg::item_t   f_item;
  logic             take;
  logic             res_push;
  logic             res_full;
  mce_pkg::result_t res_in;
  mce_pkg::result_t res_out;
  logic [4:0][7:0]  pins;

  assign pins = {port_e_in, port_d_in, port_c_in, port_b_in, port_a_in};
  assign full = q_full || clearing;

  mce_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push && !full),
    .full            (q_full),
    .instruction_word(instruction_word),
    .pins            (pins),
    .out_valid       (f_valid),
    .out_item        (f_item),
    .take            (take)
  );

  mce_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .EEPROM_DEPTH(EEPROM_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .in_valid(f_valid),
    .in_item (f_item),
    .take    (take),
    .res_push(res_push),
    .res_item(res_in),
    .res_full(res_full),
    .clearing(clearing)
  );

  mce_fifo #(
    .WIDTH($bits(mce_pkg::result_t))
  ) u_result_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .full (res_full),
    .din  (res_in),
    .pop  (pop),
    .empty(empty),
    .dout (res_out)
  );

  assign next_pc         = res_out.next_pc;
  assign w_value         = res_out.w_value;
  assign status_value    = res_out.status_value;
  assign cycles_used     = res_out.cycles_used;
  assign fault           = res_out.fault;
  assign reg_written     = res_out.reg_written;
  assign written_address = res_out.written_address;
  assign written_value   = res_out.written_value;

`ifndef SYNTHESIS
  a_fault_no_write: assert property (@(posedge clk) disable iff (rst)
    (!empty && fault != mce_pkg::FLT_OK) |-> (!reg_written && cycles_used == 2'd1))
    else $error("faulted word reports a register write");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !reg_written) |-> (written_address == 9'd0 && written_value == 8'd0))
    else $error("write fields nonzero without a write");

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!take && full))
    else $error("work taken during the clearing sweep");

  a_push_after_take: assert property (@(posedge clk) disable iff (rst)
    take |=> (res_push && !res_full))
    else $error("execute result lost");
`endif

endmodule

[tb/sv/mce_checker.sv]
module mce_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [13:0] instruction_word,
  input  logic [7:0]  port_a_in,
  input  logic [7:0]  port_b_in,
  input  logic [7:0]  port_c_in,
  input  logic [7:0]  port_d_in,
  input  logic [7:0]  port_e_in,
  input  logic        pop,
  input  logic        empty,
  input  logic [12:0] next_pc,
  input  logic [7:0]  w_value,
  input  logic [7:0]  status_value,
  input  logic [1:0]  cycles_used,
  input  logic [2:0]  fault,
  input  logic        reg_written,
  input  logic [8:0]  written_address,
  input  logic [7:0]  written_value,
  output int          failures,
  output int          pending
);

  localparam int NSTK = mce_pkg::STACK_DEPTH_DEF;
  localparam int NEE  = mce_pkg::EEPROM_DEPTH_DEF;

  logic [7:0]  regs [mce_pkg::RF_DEPTH];
  logic [12:0] pc;
  logic [7:0]  wreg;
  logic [12:0] calls [NSTK];
  int          depth;
  logic [7:0]  eedata_mem [NEE];
  mce_pkg::result_t expected_q [$];

  function automatic mce_pkg::kind_t decode_op(logic [13:0] op);
    logic [3:0] hi;
    hi = op[11:8];
    if (op < 14'h1000) begin
      if (hi == 0) begin
        if ((op & 14'h3F9F) == 0) return mce_pkg::K_NOP;
        if (op == 14'h0008) return mce_pkg::K_RET;
        if (op[7]) return mce_pkg::K_MOVWF;
        if ((op & 14'h3FFC) == 14'h0064) return mce_pkg::K_TRIS;
        return mce_pkg::K_BAD;
      end
      if (hi == 1) return op[7] ? mce_pkg::K_CLRF : mce_pkg::K_CLRW;
      return mce_pkg::kind_t'(int'(mce_pkg::K_SUBWF) + hi - 2);
    end
    if (op < 14'h2000) return mce_pkg::kind_t'(int'(mce_pkg::K_BCF) + op[11:10]);
    if (op < 14'h3000) return op[11] ? mce_pkg::K_GOTO : mce_pkg::K_CALL;
    case (op[11:10])
      2'd0: return mce_pkg::K_MOVLW;
      2'd1: return mce_pkg::K_RETLW;
      2'd2: begin
        if (hi[1:0] == 0) return mce_pkg::K_IORLW;
        if (hi[1:0] == 1) return mce_pkg::K_ANDLW;
        if (hi[1:0] == 2) return mce_pkg::K_XORLW;
        return mce_pkg::K_BAD;
      end
      default: return op[9] ? mce_pkg::K_ADDLW : mce_pkg::K_SUBLW;
    endcase
  endfunction

  function automatic mce_pkg::result_t fault_word(logic [2:0] code);
    mce_pkg::result_t r;
    r = '0;
    r.next_pc = pc;
    r.w_value = wreg;
    r.status_value = regs[mce_pkg::A_STATUS];
    r.cycles_used = 2'd1;
    r.fault = code;
    return r;
  endfunction

  function automatic mce_pkg::result_t execute_op(logic [13:0] op, logic [4:0][7:0] pins);
    mce_pkg::kind_t kind;
    logic [8:0] a, low;
    logic [7:0] st, v, res, stored, tris;
    logic [12:0] npc;
    logic [1:0] cyc;
    logic [2:0] bitn;
    int sum;
    int ea;
    bit ind, rd, to_f, to_w, zf, cf, cval, skip;
    int stk;
    mce_pkg::result_t r;
    kind = decode_op(op);
    bitn = op[9:7];
    npc = pc + 13'd1;
    cyc = 2'd1;
    ind = 0; to_f = 0; to_w = 0; zf = 0; cf = 0; cval = 0; skip = 0; stk = 0;
    a = '0; v = '0; res = '0; stored = '0;
    if (kind == mce_pkg::K_BAD) return fault_word(mce_pkg::FLT_BADOP);
    if (kind == mce_pkg::K_CALL && depth >= NSTK) return fault_word(mce_pkg::FLT_OVF);
    if ((kind == mce_pkg::K_RET || kind == mce_pkg::K_RETLW) && depth == 0)
      return fault_word(mce_pkg::FLT_UNF);
    rd = kind >= mce_pkg::K_SUBWF && kind <= mce_pkg::K_BTFSS;
    if (rd || kind == mce_pkg::K_MOVWF || kind == mce_pkg::K_CLRF) begin
      st = regs[mce_pkg::A_STATUS];
      a = {st[6:5], op[6:0]};
      low = {2'b0, op[6:0]};
      if (low == 0) begin
        ind = 1;
        a = {st[7], regs[mce_pkg::A_FSR]};
      end else if (low == mce_pkg::A_PCL || low == mce_pkg::A_STATUS ||
                   low == mce_pkg::A_FSR || low == mce_pkg::A_PCLATH)
        a = low;
    end
    if (rd) begin
      v = regs[a];
      if (!ind) begin
        if (a == mce_pkg::A_PCL) v = pc[7:0] + 8'd1;
        else if (a >= mce_pkg::A_PORTA && a <= mce_pkg::A_PORTE) begin
          tris = regs[a + 9'h080];
          v = (v & ~tris) | (pins[a - mce_pkg::A_PORTA] & tris);
        end else if (a == mce_pkg::A_PIR1) v = v | 8'h10;
        else if (a == mce_pkg::A_TXSTA) v = v | 8'h02;
      end
    end
    if (kind >= mce_pkg::K_SUBWF && kind <= mce_pkg::K_INCFSZ) begin
      to_f = op[7];
      to_w = !op[7];
    end
    case (kind)
      mce_pkg::K_RETLW: begin res = op[7:0]; to_w = 1; stk = -1; end
      mce_pkg::K_RET: stk = -1;
      mce_pkg::K_MOVWF: begin res = wreg; to_f = 1; end
      mce_pkg::K_TRIS: if (op[1:0] != 0) begin
        a = mce_pkg::A_TRIS_BASE + op[1:0]; ind = 1; res = wreg; to_f = 1;
      end
      mce_pkg::K_CLRF: begin res = 8'd0; to_f = 1; zf = 1; end
      mce_pkg::K_CLRW: begin res = 8'd0; to_w = 1; zf = 1; end
      mce_pkg::K_SUBWF: begin res = v - wreg; cf = 1; cval = v >= wreg; zf = 1; end
      mce_pkg::K_DECF: begin res = v - 8'd1; zf = 1; end
      mce_pkg::K_IORWF: begin res = v | wreg; zf = 1; end
      mce_pkg::K_ANDWF: begin res = v & wreg; zf = 1; end
      mce_pkg::K_XORWF: begin res = v ^ wreg; zf = 1; end
      mce_pkg::K_ADDWF: begin
        sum = v + wreg; res = sum[7:0]; cf = 1; cval = sum > 255; zf = 1;
      end
      mce_pkg::K_MOVF: begin res = v; zf = 1; end
      mce_pkg::K_COMF: begin res = ~v; zf = 1; end
      mce_pkg::K_INCF: begin res = v + 8'd1; zf = 1; end
      mce_pkg::K_DECFSZ: begin res = v - 8'd1; skip = res == 0; end
      mce_pkg::K_INCFSZ: begin res = v + 8'd1; skip = res == 0; end
      mce_pkg::K_RRF: begin
        res = {regs[mce_pkg::A_STATUS][0], v[7:1]}; cf = 1; cval = v[0];
      end
      mce_pkg::K_RLF: begin
        res = {v[6:0], regs[mce_pkg::A_STATUS][0]}; cf = 1; cval = v[7];
      end
      mce_pkg::K_SWAPF: res = {v[3:0], v[7:4]};
      mce_pkg::K_BCF: begin res = v; res[bitn] = 1'b0; to_f = 1; end
      mce_pkg::K_BSF: begin res = v; res[bitn] = 1'b1; to_f = 1; end
      mce_pkg::K_BTFSC: skip = !v[bitn];
      mce_pkg::K_BTFSS: skip = v[bitn];
      mce_pkg::K_CALL, mce_pkg::K_GOTO: begin
        if (kind == mce_pkg::K_CALL) stk = 1;
        npc = {regs[mce_pkg::A_PCLATH][4:3], op[10:0]};
        cyc = 2'd2;
      end
      mce_pkg::K_MOVLW: begin res = op[7:0]; to_w = 1; end
      mce_pkg::K_IORLW: begin res = wreg | op[7:0]; to_w = 1; zf = 1; end
      mce_pkg::K_ANDLW: begin res = wreg & op[7:0]; to_w = 1; zf = 1; end
      mce_pkg::K_XORLW: begin res = wreg ^ op[7:0]; to_w = 1; zf = 1; end
      mce_pkg::K_SUBLW: begin
        res = op[7:0] - wreg; to_w = 1; cf = 1; cval = op[7:0] >= wreg; zf = 1;
      end
      mce_pkg::K_ADDLW: begin
        sum = op[7:0] + wreg; res = sum[7:0]; to_w = 1; cf = 1; cval = sum > 255; zf = 1;
      end
      default: ;
    endcase
    if (skip) begin npc = pc + 13'd2; cyc = 2'd2; end
    if (to_f && !ind && a == mce_pkg::A_EECON1 && res[7] && res[1:0] != 0)
      return fault_word(mce_pkg::FLT_PMEM);
    if (rd && !ind) begin
      if (a == mce_pkg::A_RCREG) regs[mce_pkg::A_PIR1][5] = 1'b0;
      else if (a == mce_pkg::A_PIR1) regs[mce_pkg::A_PIR1][4] = 1'b1;
      else if (a == mce_pkg::A_TXSTA) regs[mce_pkg::A_TXSTA][1] = 1'b1;
    end
    if (to_f) begin
      stored = res;
      if (!ind) begin
        if (a == mce_pkg::A_PCL) begin
          npc = {regs[mce_pkg::A_PCLATH][4:0], res};
          cyc = 2'd2;
        end else if (a == mce_pkg::A_RCSTA) begin
          stored[1] = res[4] ? regs[mce_pkg::A_RCSTA][1] : 1'b0;
        end else if (a == mce_pkg::A_EECON1) begin
          ea = regs[mce_pkg::A_EEADR] % NEE;
          if (res[0]) begin
            regs[mce_pkg::A_EEDATA] = eedata_mem[ea];
            stored[0] = 1'b0;
          end else if (res[1]) begin
            eedata_mem[ea] = regs[mce_pkg::A_EEDATA];
            stored[1] = 1'b0;
          end
        end
      end
      regs[a] = stored;
    end
    if (to_w) wreg = res;
    if (zf) regs[mce_pkg::A_STATUS][2] = res == 0;
    if (cf) regs[mce_pkg::A_STATUS][0] = cval;
    if (stk > 0) begin
      calls[depth] = pc + 13'd1;
      depth++;
    end else if (stk < 0) begin
      depth--;
      npc = calls[depth];
      cyc = 2'd2;
    end
    pc = npc;
    r.next_pc = npc;
    r.w_value = wreg;
    r.status_value = regs[mce_pkg::A_STATUS];
    r.cycles_used = cyc;
    r.fault = mce_pkg::FLT_OK;
    r.reg_written = to_f;
    r.written_address = to_f ? a : '0;
    r.written_value = to_f ? stored : '0;
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    mce_pkg::result_t e;
    if (rst) begin
      foreach (regs[i]) regs[i] = '0;
      foreach (calls[i]) calls[i] = '0;
      foreach (eedata_mem[i]) eedata_mem[i] = '0;
      pc = '0;
      wreg = '0;
      depth = 0;
      expected_q.delete();
      failures = 0;
    end else begin
      if (push && !full)
        expected_q.push_back(execute_op(instruction_word,
          {port_e_in, port_d_in, port_c_in, port_b_in, port_a_in}));
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          failures++;
        end else begin
          e = expected_q.pop_front();
          compare_field("next_pc", e.next_pc, next_pc);
          compare_field("w_value", e.w_value, w_value);
          compare_field("status_value", e.status_value, status_value);
          compare_field("cycles_used", e.cycles_used, cycles_used);
          compare_field("fault", e.fault, fault);
          compare_field("reg_written", e.reg_written, reg_written);
          compare_field("written_address", e.written_address, written_address);
          compare_field("written_value", e.written_value, written_value);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

[tb/sv/testbench.sv]
module testbench;

  logic        clk, rst, push, pop, full, empty;
  logic [13:0] instruction_word;
  logic [7:0]  port_a_in, port_b_in, port_c_in, port_d_in, port_e_in;
  logic [12:0] next_pc;
  logic [7:0]  w_value, status_value, written_value;
  logic [1:0]  cycles_used;
  logic [2:0]  fault;
  logic        reg_written;
  logic [8:0]  written_address;
  int          failures, pending;
  int          send_idle, recv_idle, cycle_count;
  bit          hold_pop;

  midrange_8bit_core_execute DUT (.*);

  mce_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("midrange_8bit_core_execute regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !hold_pop && ($urandom_range(99) >= recv_idle);
  end

  // Pick instructions that stay near the interesting registers.
  function automatic logic [13:0] pick_op();
    logic [6:0] f;
    int sel;
    sel = $urandom_range(99);
    case ($urandom_range(7))
      0: f = 7'h00;
      1: f = 7'(7'h02 + $urandom_range(2));
      2: f = 7'(7'h05 + $urandom_range(4));
      3: f = $urandom_range(1) ? 7'h0C : 7'h1A;
      4: f = 7'h18;
      5: f = $urandom_range(1) ? 7'h0C : 7'h0D;
      default: f = 7'($urandom_range(127));
    endcase
    if (sel < 8) return 14'(14'h3000 | $urandom_range(16'hFFF));
    if (sel < 12) return 14'(14'h2000 | $urandom_range(16'h7FF));
    if (sel < 18) return 14'h0008;
    if (sel < 22) return 14'(14'h3400 | $urandom_range(255));
    if (sel < 24) return 14'(14'h0064 + $urandom_range(3));
    if (sel < 26) return 14'(14'h2800 | $urandom_range(16'h7FF));
    if (sel < 28) return 14'($urandom_range(16'h3FFF));
    if (sel < 36) return 14'(14'h0080 | f);
    if (sel < 50) return {3'b01, 2'($urandom_range(3)), 3'($urandom_range(7)), f};
    if (sel < 90) return {2'b00, 4'($urandom_range(2, 15)), 1'($urandom_range(1)), f};
    return {2'b11, 4'($urandom_range(15)), 8'($urandom_range(255))};
  endfunction

  // Leave push high when the next word follows at once.
  task automatic send_word(logic [13:0] op);
    instruction_word <= op;
    port_a_in <= 8'($urandom_range(255));
    port_b_in <= 8'($urandom_range(255));
    port_c_in <= 8'($urandom_range(255));
    port_d_in <= 8'($urandom_range(255));
    port_e_in <= 8'($urandom_range(255));
    push <= 1'b1;
    do @(posedge clk); while (full);
    if ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  initial begin
    logic [13:0] directed [] = '{
      14'h3FFF, 14'h3000, 14'h3EFF, 14'h3C00, 14'h30FF, 14'h3900, 14'h3A55,
      14'h3BFF, 14'h0000, 14'h0064, 14'h0065, 14'h0066, 14'h0067, 14'h0009,
      14'h0008, 14'h3401, 14'h2000, 14'h0082, 14'h1683, 14'h3081, 14'h008C,
      14'h1283, 14'h2FFF, 14'h0185, 14'h0103};
    rst = 1;
    push = 0;
    hold_pop = 0;
    cycle_count = 0;
    send_idle = 0;
    recv_idle = 0;
    instruction_word = '0;
    {port_a_in, port_b_in, port_c_in, port_d_in, port_e_in} = '0;
    repeat (8) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_word(directed[i]);
    // Hold the result side off so the block backs up and stalls push.
    fork
      begin
        hold_pop = 1;
        repeat (60) @(posedge clk);
        hold_pop = 0;
      end
      repeat (20) send_word(pick_op());
    join
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 78 : 9) : 0;
      recv_idle = (ph == 2) ? 78 : (ph == 3 ? 9 : 0);
      repeat (230) send_word(pick_op());
    end
    push <= 1'b0;
    send_idle = 0;
    recv_idle = 0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0) $display("midrange_8bit_core_execute regression: pass");
    else $display("midrange_8bit_core_execute regression: fail");
    $finish;
  end
endmodule
